### rtl/fkh_pkg.sv
package fkh_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h1EDC_6F41;

    // Register index taken from paddr[2] (registers sit on 4-byte strides)
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic             load;   // seed was written this cycle
        logic [CRC_W-1:0] seed;   // seed value in force after this cycle
    } t_cfg;

endpackage

### rtl/flow_key_crc32c_hash_unit.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------
// key in   | input     | i_in_valid / o_in_stall | i_key_byte[7:0], i_last_byte
// hash out | output    | o_out_valid/i_out_stall | o_hash_value[31:0]
// config   | APB       | psel/penable/pready     | seed at byte address 0
//
// One key byte per cycle unless o_in_stall is high: a byte is captured in
// the input register, folded into the running CRC by one XOR network, and
// on the last byte the hash lands in the output register.
// Reset (synchronous, active low) clears seed and running CRC to zero.
// Non-last bytes keep moving while a hash waits; only a last byte holds in
// the input register while the output register is full and stalled.
// A seed write reloads the running CRC at once, dropping any partial key.
module flow_key_crc32c_hash_unit
    import fkh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // key byte channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_key_byte,
    input  logic               i_last_byte,
    // hash channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CRC_W-1:0]   o_hash_value,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg cfg;

    // input register
    logic              r_in_valid;
    logic              n_in_valid;
    logic [BYTE_W-1:0] r_key_byte;
    logic              r_last_byte;

    // running CRC and output register
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;
    logic [CRC_W-1:0]  fold_crc;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [CRC_W-1:0]  r_hash;

    logic              out_free;
    logic              fold_fire;
    logic              in_take;

    fkh_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fkh_crc_fold u_crc_fold (
        .i_crc  (r_crc),
        .i_data (r_key_byte),
        .o_crc  (fold_crc)
    );

    // The output register can take a hash when empty or drained this cycle.
    assign out_free  = !r_out_valid || !i_out_stall;
    // Fold the held byte unless it is a last byte with nowhere to go.
    assign fold_fire = r_in_valid && (!r_last_byte || out_free);
    assign o_in_stall = r_in_valid && !fold_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign n_in_valid = in_take || (r_in_valid && !fold_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload: load on every accepted transaction, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key_byte  <= i_key_byte;
            r_last_byte <= i_last_byte;
        end
    end

    // Seed write wins; a last byte restarts from the seed.
    always_comb begin
        n_crc = r_crc;
        if (cfg.load) begin
            n_crc = cfg.seed;
        end else if (fold_fire) begin
            n_crc = r_last_byte ? cfg.seed : fold_crc;
        end
    end

    assign n_out_valid = (fold_fire && r_last_byte) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fold_fire && r_last_byte) begin
            r_hash <= fold_crc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    // A last byte never overwrites a hash that is still waiting.
    a_no_hash_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fold_fire && r_last_byte && r_out_valid && i_out_stall))
        else $error("hash overwritten while output stalled");

    // A seed write reloads the running CRC.
    a_seed_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg.load |=> (r_crc == cfg.seed))
        else $error("running CRC not reloaded after seed write");

    // After a finished key the running CRC restarts from the seed and a hash is valid.
    a_key_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fold_fire && r_last_byte) |=> (r_crc == cfg.seed) && r_out_valid)
        else $error("running CRC not restarted after last byte");

    // A hash shown on the output came from a folded last byte or was held.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fold_fire && r_last_byte))
        else $error("hash appeared without a last byte");

endmodule

### rtl/fkh_crc_fold.sv
module fkh_crc_fold
    import fkh_pkg::*;
(
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_data,
    output logic [CRC_W-1:0]  o_crc
);

    // Eight serial CRC steps, MSB first; flattens into one XOR network.
    always_comb begin
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = i_crc;
        for (int b = 0; b < BYTE_W; b++) begin
            fb  = crc[CRC_W-1] ^ i_data[BYTE_W-1-b];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        o_crc = crc;
    end

endmodule

### rtl/fkh_cfg_regs.sv
module fkh_cfg_regs
    import fkh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [CRC_W-1:0] r_seed;
    logic [CRC_W-1:0] n_seed;
    logic             wr_seed;

    assign pready  = 1'b1;
    assign wr_seed = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign n_seed  = wr_seed ? pwdata : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else begin
            r_seed <= n_seed;
        end
    end

    assign prdata     = (paddr[2] == REG_SEED) ? r_seed : '0;
    assign o_cfg.load = wr_seed;
    // pass the written value through so a reload picks up the new seed
    assign o_cfg.seed = n_seed;

endmodule

### tb/flow_key_hash_checker.sv
`timescale 1ns / 100ps

module flow_key_hash_checker
    import fkh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_key_byte,
    input  logic               i_last_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [CRC_W-1:0]   i_hash_value,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [CRC_W-1:0] seed_reg;
    logic [CRC_W-1:0] key_crc;
    logic [CRC_W-1:0] pending_hashes[$];
    int               fails = 0;

    // MSB-first, non-reflected CRC step over one key byte
    function automatic logic [CRC_W-1:0] fold_key_byte(logic [CRC_W-1:0] crc,
                                                       logic [BYTE_W-1:0] kb);
        logic feedback;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            feedback = crc[CRC_W-1] ^ kb[k];
            crc      = {crc[CRC_W-2:0], 1'b0};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [CRC_W-1:0] want;
        if (!i_rst_n) begin
            seed_reg = '0;
            key_crc  = '0;
            pending_hashes.delete();
        end else begin
            // retire the oldest hash first; a hash never leaves in the edge its byte enters
            if (i_out_valid && !i_out_stall) begin
                if (pending_hashes.size() == 0) begin
                    $error("hash_value: no hash pending, got %08h", i_hash_value);
                    fails++;
                end else begin
                    want = pending_hashes.pop_front();
                    if (i_hash_value !== want) begin
                        $error("hash_value: expected %08h, got %08h", want, i_hash_value);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                key_crc = fold_key_byte(key_crc, i_key_byte);
                if (i_last_byte) begin
                    pending_hashes.push_back(key_crc);
                    key_crc = seed_reg;
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_SEED) begin
                if (i_pwrite) begin
                    seed_reg = i_pwdata;
                    key_crc  = i_pwdata;
                end else if (i_prdata !== seed_reg) begin
                    $error("seed: expected %08h, got %08h", seed_reg, i_prdata);
                    fails++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_hashes.size();
    end

endmodule

### tb/tb_flow_key_crc32c_hash_unit.sv
`timescale 1ns / 100ps

module tb_flow_key_crc32c_hash_unit
    import fkh_pkg::*;
();

    localparam int unsigned        TOTAL_BYTES = 1050;
    localparam int unsigned        PHASE_BYTES = 130;
    localparam int unsigned        HOLD_CYCLES = 300;
    localparam int unsigned        IDLE_PCT    = 18;
    // seed sits at byte address 0; the next 4-byte slot holds no register
    localparam logic [PADDR_W-1:0] SEED_ADDR   = {REG_SEED, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_SEED, 2'b00};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_key_byte;
    logic               i_last_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [CRC_W-1:0]   o_hash_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int unsigned        bytes_sent = 0;
    bit                 calm_phase = 1'b0;   // no idling on either side
    bit                 hold_req   = 1'b0;   // ask the hash sink for a long hold-off

    always #10 i_clk = ~i_clk;

    flow_key_crc32c_hash_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_key_byte   (i_key_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    flow_key_hash_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_key_byte   (i_key_byte),
        .i_last_byte  (i_last_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_hash_value (o_hash_value),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Setup cycle, then access cycle; hold the access until pready
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The checker compares prdata against its own copy of the seed.
    // Wait for a clock edge first so any previous access closes.
    task automatic apb_read(input logic [PADDR_W-1:0] addr);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one key byte and hold it until the transaction completes.
    // Valid only drops when a gap is inserted, so it never toggles within a step.
    task automatic send_byte(input logic [BYTE_W-1:0] kb, input logic last);
        if (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_key_byte  <= kb;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Random key content; leave it open when seal is clear
    task automatic send_key(input int unsigned len, input bit seal);
        for (int unsigned n = 1; n <= len; n++) begin
            send_byte(BYTE_W'($urandom_range(255)), seal && n == len);
        end
    endtask

    // Stop offering, wait for every hash, then let any partial key settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Hash sink: random stalls, quiet stretches, and one long hold-off
    initial begin : hash_sink
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (calm_phase) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin : key_source
        int unsigned      phase_no;
        int unsigned      phase_start;
        int unsigned      key_len;
        logic [CRC_W-1:0] seed_val;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_key_byte  <= '0;
        i_last_byte <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset seed of zero: byte extremes, single-bit bytes, a short key
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // All-ones seed
        drain();
        apb_write(SEED_ADDR, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // Write to the empty slot: must leave the seed alone
        drain();
        apb_write(UNUSED_ADDR, 32'h1234_5678);
        send_byte(8'hC3, 1'b1);

        // Seed written mid-key: drop the open key and restart from the new seed
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        drain();
        apb_write(SEED_ADDR, 32'h8000_0000);
        apb_read(SEED_ADDR);
        send_byte(8'h33, 1'b1);

        // Random keys, one seed per phase
        phase_no = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            case (phase_no)
                0:       seed_val = 32'hFFFF_FFFF;
                1:       seed_val = 32'h0000_0000;
                2:       seed_val = 32'h8000_0000;
                3:       seed_val = 32'h0000_0001;
                default: seed_val = $urandom;
            endcase
            drain();
            apb_write(SEED_ADDR, seed_val);
            apb_read(SEED_ADDR);
            calm_phase = (phase_no == 2);

            // Back-pressure: hold the sink off and keep offering one-byte keys
            if (phase_no == 4) begin
                calm_phase = 1'b1;
                hold_req   = 1'b1;
                repeat (60) send_byte(BYTE_W'($urandom_range(255)), 1'b1);
                calm_phase = 1'b0;
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                key_len = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                                    : $urandom_range(13, 40);
                send_key(key_len, 1'b1);
            end

            // Sometimes leave a key open; the next seed write abandons it
            if ($urandom_range(3) == 0) begin
                send_key($urandom_range(1, 6), 1'b0);
            end
            if (phase_no % 3 == 1) begin
                drain();
                apb_write(UNUSED_ADDR, $urandom);
            end
            calm_phase = 1'b0;
            phase_no++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
